// ===== hw/rtl/bsd_pkg.sv =====
// Shared types and constants of the block sum downsample unit.
package bsd_pkg;

  // Field and register widths
  localparam int ValueW       = 32;
  localparam int SumW         = 38;
  localparam int ScaleW       = 4;
  localparam int PlaneWidthW  = 11;
  localparam int PlaneHeightW = 13;
  localparam int RowW         = 12;
  localparam int HeightLimit  = 4096;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 13;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgScale       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPlaneWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPlaneHeight = 2'd2;

  // Register reset values
  localparam logic [ScaleW-1:0]       ScaleRst       = 4'd2;
  localparam logic [PlaneWidthW-1:0]  PlaneWidthRst  = 11'd1;
  localparam logic [PlaneHeightW-1:0] PlaneHeightRst = 13'd1;

  // Output queue
  localparam int OutDepth = 4;
  localparam int OutPtrW  = 2;
  localparam int OutCntW  = 3;

  typedef struct packed {
    logic emit;       // last value of a block: send the sum, clear the entry
    logic plane_end;  // last block of the plane
  } bsd_step_t;

  typedef struct packed {
    logic                   plane_end;
    logic signed [SumW-1:0] sum;
  } bsd_result_t;

endpackage

// ===== hw/rtl/block_sum_downsample_2d_unit.sv =====
// Top level: backward nearest-neighbor upsampling as block sum pooling.
//
//  channel  dir  beat holds                       notes
//  s_axis   in   tdata[31:0] grad_value          Q16.16, raster order of the large plane
//  m_axis   out  tdata[37:0] grad_sum, tlast     Q22.16 block sum, tlast = plane end
//  cfg      in   cfg_idx_i / cfg_data_i          0 scale, 1 plane_width, 2 plane_height
//
//  One input beat per cycle while s_axis_tready_o is high; a block sum passes
//  through stage 1 and the result queue before it shows on m_axis. The rate is
//  set by the single read-modify-write of the accumulator RAM per beat, read in
//  the accept cycle and written in the next one.
//  After reset a clearing pass zeroes all MAX_WIDTH entries of the accumulator
//  RAM with s_axis_tready_o low; configuration writes are taken meanwhile. Outside
//  that pass s_axis_tready_o drops only when the four-entry result queue could overflow.
module block_sum_downsample_2d_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [bsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bsd_pkg::CfgDataW-1:0] cfg_data_i,
  // gradient input
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [31:0]                  s_axis_tdata_i,   // [31:0] grad_value
  // block sum output
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [39:0]                  m_axis_tdata_o,   // [37:0] grad_sum, [39:38] zero
  output logic                         m_axis_tlast_o    // plane_end
);
  import bsd_pkg::*;

  localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // clearing pass
  logic             clr_active_q;
  logic [AddrW-1:0] clr_addr_q;

  // stage 0: accept, counters, RAM read
  logic             in_fire;
  logic [AddrW-1:0] col;
  bsd_step_t        step;

  // stage 1: accumulate, write back, queue result
  logic                     s1_valid_q;
  logic [AddrW-1:0]         s1_addr_q;
  logic [ValueW-1:0]        s1_value_q;
  bsd_step_t                s1_step_q;
  logic [SumW-1:0]          rd_data;
  logic [SumW-1:0]          base, sum, wr_data;

  // last write, for a read that raced it
  logic                     fwd_valid_q;
  logic [AddrW-1:0]         fwd_addr_q;
  logic [SumW-1:0]          fwd_data_q;

  // RAM port muxing
  logic                     ram_we;
  logic [AddrW-1:0]         ram_waddr;
  logic [SumW-1:0]          ram_wdata;

  // result queue
  bsd_result_t              res, head;
  logic                     res_push;
  logic [OutCntW-1:0]       q_count;
  logic                     q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(MAX_WIDTH - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // room for this beat's result, behind the queue and the one in stage 1
  assign s_axis_tready_o = !clr_active_q &&
    ((q_count + OutCntW'(s1_valid_q & s1_step_q.emit)) < OutCntW'(OutDepth));
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  bsd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (in_fire),
    .col_o      (col),
    .step_o     (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_addr_q  <= col;
      s1_value_q <= s_axis_tdata_i;
      s1_step_q  <= step;
    end
  end

  // the newest write wins over the RAM copy
  assign base = (fwd_valid_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_data;
  assign sum  = base + {{(SumW - ValueW){s1_value_q[ValueW-1]}}, s1_value_q};
  assign wr_data = s1_step_q.emit ? '0 : sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_valid_q) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= wr_data;
    end
  end

  assign ram_we    = clr_active_q || s1_valid_q;
  assign ram_waddr = clr_active_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_active_q ? '0 : wr_data;

  bsd_ram #(
    .Width (SumW),
    .Depth (MAX_WIDTH),
    .AddrW (AddrW)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (col),
    .rdata_o (rd_data)
  );

  assign res_push      = s1_valid_q && s1_step_q.emit;
  assign res.sum       = sum;
  assign res.plane_end = s1_step_q.plane_end;

  bsd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .pop_i       (m_axis_tready_i),
    .valid_o     (q_valid),
    .head_o      (head),
    .count_o     (q_count)
  );

  assign m_axis_tvalid_o = q_valid;
  assign m_axis_tdata_o  = {2'b00, head.sum};
  assign m_axis_tlast_o  = head.plane_end;

endmodule

// ===== hw/rtl/bsd_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
module bsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bsd_ctrl.sv =====
// Configuration registers and raster position counters.
module bsd_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 8,
  parameter int AddrW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bsd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                     advance_i,
  output logic [AddrW-1:0]         col_o,
  output bsd_pkg::bsd_step_t       step_o
);
  import bsd_pkg::*;

  localparam int SubW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SEW  = ($clog2(MAX_SCALE + 1) > ScaleW) ? $clog2(MAX_SCALE + 1) : ScaleW;
  localparam int WEW  = ($clog2(MAX_WIDTH + 1) > PlaneWidthW) ?
                        $clog2(MAX_WIDTH + 1) : PlaneWidthW;

  logic [ScaleW-1:0]       scale_q;
  logic [PlaneWidthW-1:0]  width_q;
  logic [PlaneHeightW-1:0] height_q;

  logic [SubW-1:0]  sub_col_q, sub_col_d;
  logic [SubW-1:0]  sub_row_q, sub_row_d;
  logic [AddrW-1:0] col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;

  logic [SEW-1:0]          s_eff, s_m1;
  logic [WEW-1:0]          w_eff, w_m1;
  logic [PlaneHeightW-1:0] h_eff, h_m1;
  logic last_sc, last_sr, last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleRst;
      width_q  <= PlaneWidthRst;
      height_q <= PlaneHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScale:       scale_q  <= cfg_data_i[ScaleW-1:0];
        CfgPlaneWidth:  width_q  <= cfg_data_i[PlaneWidthW-1:0];
        CfgPlaneHeight: height_q <= cfg_data_i[PlaneHeightW-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, oversize counts as the limit
  always_comb begin
    if (scale_q == '0) begin
      s_eff = SEW'(1);
    end else if (SEW'(scale_q) > SEW'(MAX_SCALE)) begin
      s_eff = SEW'(MAX_SCALE);
    end else begin
      s_eff = SEW'(scale_q);
    end
    if (width_q == '0) begin
      w_eff = WEW'(1);
    end else if (WEW'(width_q) > WEW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = PlaneHeightW'(1);
    end else if (height_q > PlaneHeightW'(HeightLimit)) begin
      h_eff = PlaneHeightW'(HeightLimit);
    end else begin
      h_eff = height_q;
    end
    s_m1 = s_eff - SEW'(1);
    w_m1 = w_eff - WEW'(1);
    h_m1 = h_eff - PlaneHeightW'(1);
  end

  assign last_sc  = SEW'(sub_col_q) >= s_m1;
  assign last_sr  = SEW'(sub_row_q) >= s_m1;
  assign last_col = WEW'(col_q) >= w_m1;
  assign last_row = PlaneHeightW'(row_q) >= h_m1;

  always_comb begin
    sub_col_d = sub_col_q;
    sub_row_d = sub_row_q;
    col_d     = col_q;
    row_d     = row_q;
    if (!last_sc) begin
      sub_col_d = sub_col_q + SubW'(1);
    end else begin
      sub_col_d = '0;
      if (!last_col) begin
        col_d = col_q + AddrW'(1);
      end else begin
        col_d = '0;
        if (!last_sr) begin
          sub_row_d = sub_row_q + SubW'(1);
        end else begin
          sub_row_d = '0;
          row_d     = last_row ? '0 : row_q + RowW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_col_q <= '0;
      sub_row_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else if (advance_i) begin
      sub_col_q <= sub_col_d;
      sub_row_q <= sub_row_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

  assign col_o            = col_q;
  assign step_o.emit      = last_sc & last_sr;
  assign step_o.plane_end = last_sc & last_sr & last_col & last_row;

endmodule

// ===== hw/rtl/bsd_out_fifo.sv =====
// Small result queue between the accumulate stage and the output port.
module bsd_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  bsd_pkg::bsd_result_t         push_data_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output bsd_pkg::bsd_result_t         head_o,
  output logic [bsd_pkg::OutCntW-1:0]  count_o
);
  import bsd_pkg::*;

  bsd_result_t          mem_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0]   count_q;
  logic                 do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OutPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      end
      unique case ({push_i, do_pop})
        2'b10:   count_q <= count_q + OutCntW'(1);
        2'b01:   count_q <= count_q - OutCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule
